>>> src/mft_pkg.sv
// Shared types and constants for the motor feedback multi-turn tracker.
package mft_pkg;

  localparam int ID_W        = 11;
  localparam int PAYLOAD_W   = 64;
  localparam int SLOT_W      = 2;
  localparam int SLOT_ID_W   = 4;
  localparam int MAX_IDS     = 4;
  localparam int WINDOW_SPAN = 10;
  localparam int ENC_WRAP    = 8191;
  localparam int HALF_TURN   = 4096;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int COUNT_W     = 3;

  localparam logic [ID_W-1:0]      BASE_ID_RST     = 11'd512;
  localparam logic [COUNT_W-1:0]   MOTOR_COUNT_RST = 3'd4;
  localparam logic [CFG_DATA_W-1:0] SLOT_IDS_RST   = 16'h4321;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE_ID     = 2'd0,
    CFG_MOTOR_COUNT = 2'd1,
    CFG_SLOT_IDS    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic signed [15:0] angle;
    logic signed [15:0] speed;
    logic signed [15:0] torque;
    logic [7:0]         temperature;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic signed [15:0] angle;
    logic signed [15:0] speed;
    logic signed [15:0] torque;
    logic [7:0]         temperature;
    logic signed [31:0] total_angle;
    logic signed [15:0] start_angle;
  } result_t;

  typedef struct packed {
    logic  valid;
    logic  full;
    item_t item;
  } queue_status_t;

endpackage

>>> src/mft_ifs.sv
// Channel interfaces: frame input, result output and configuration write.
interface mft_in_if;
  import mft_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ID_W-1:0]      frame_id;
  logic [PAYLOAD_W-1:0] payload;
  modport source (output valid, output frame_id, output payload, input ready);
  modport sink   (input valid, input frame_id, input payload, output ready);
endinterface

interface mft_out_if;
  import mft_pkg::*;
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  motor_slot;
  logic signed [15:0] angle;
  logic signed [15:0] speed;
  logic signed [15:0] torque;
  logic [7:0]         temperature;
  logic signed [31:0] total_angle;
  logic signed [15:0] start_angle;
  modport source (output valid, output motor_slot, output angle, output speed,
                  output torque, output temperature, output total_angle,
                  output start_angle, input ready);
  modport sink   (input valid, input motor_slot, input angle, input speed,
                  input torque, input temperature, input total_angle,
                  input start_angle, output ready);
endinterface

interface mft_cfg_if;
  import mft_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/mft_front.sv
// Front end: configuration registers, identifier window check and slot match.
module mft_front import mft_pkg::*; #(
  parameter int USED_SLOTS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  mft_cfg_if.sink       cfg_ch,
  mft_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output item_t         push_item
);

  localparam logic [COUNT_W-1:0] USED_CNT = COUNT_W'(USED_SLOTS);

  logic [ID_W-1:0]       base_id_r;
  logic [COUNT_W-1:0]    motor_count_r;
  logic [CFG_DATA_W-1:0] slot_ids_r;

  logic [ID_W:0]         base_ext;
  logic [ID_W:0]         fid_ext;
  logic                  in_window;
  logic [COUNT_W-1:0]    count_eff;
  logic                  hit;
  logic [SLOT_W-1:0]     hit_slot;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r     <= BASE_ID_RST;
      motor_count_r <= MOTOR_COUNT_RST;
      slot_ids_r    <= SLOT_IDS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_BASE_ID:     base_id_r     <= cfg_ch.data[ID_W-1:0];
        CFG_MOTOR_COUNT: motor_count_r <= cfg_ch.data[COUNT_W-1:0];
        CFG_SLOT_IDS:    slot_ids_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    base_ext  = {1'b0, base_id_r};
    fid_ext   = {1'b0, in_ch.frame_id};
    in_window = (fid_ext >= base_ext) &&
                (fid_ext <= base_ext + (ID_W+1)'(WINDOW_SPAN));
    count_eff = (motor_count_r > USED_CNT) ? USED_CNT : motor_count_r;
    hit       = 1'b0;
    hit_slot  = '0;
    // lowest matching slot wins
    for (int i = MAX_IDS - 1; i >= 0; i--) begin
      if ((COUNT_W'(i) < count_eff) &&
          (base_ext + (ID_W+1)'(slot_ids_r[i*SLOT_ID_W +: SLOT_ID_W]) == fid_ext)) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full && in_window && hit;

  assign push_item.slot        = hit_slot;
  assign push_item.angle       = in_ch.payload[63:48];
  assign push_item.speed       = in_ch.payload[47:32];
  assign push_item.torque      = in_ch.payload[31:16];
  assign push_item.temperature = in_ch.payload[15:8];

endmodule

>>> src/mft_queue.sv
// Short FIFO between the front end and the accumulation back end.
module mft_queue import mft_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  item_t         push_item,
  input  logic          pop,
  output queue_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign status.valid = (count_r != '0);
  assign status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign status.item  = mem_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && status.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> src/mft_back.sv
// Back end: per-slot multi-turn accumulation and registered result output.
module mft_back import mft_pkg::*; #(
  parameter int USED_SLOTS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  queue_status_t q_status,
  output logic          pop,
  mft_out_if.source     out_ch
);

  logic signed [15:0] prev_angle_r  [USED_SLOTS];
  logic signed [31:0] total_r       [USED_SLOTS];
  logic signed [15:0] first_angle_r [USED_SLOTS];
  logic [USED_SLOTS-1:0] seen_r;

  logic               out_valid_r;
  result_t            out_r;

  item_t              item;
  logic [USED_SLOTS-1:0] sel;
  logic               cur_seen;
  logic signed [15:0] cur_prev;
  logic signed [31:0] cur_total;
  logic signed [15:0] cur_first;
  logic signed [16:0] diff;
  logic signed [17:0] delta;
  logic signed [33:0] sum;
  logic signed [31:0] sat;
  logic signed [31:0] new_total;
  logic signed [15:0] new_start;
  result_t            result_nxt;

  assign item = q_status.item;
  assign pop  = q_status.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    cur_seen  = 1'b0;
    cur_prev  = '0;
    cur_total = '0;
    cur_first = '0;
    for (int i = 0; i < USED_SLOTS; i++) begin
      sel[i] = (item.slot == SLOT_W'(i));
      if (sel[i]) begin
        cur_seen  = seen_r[i];
        cur_prev  = prev_angle_r[i];
        cur_total = total_r[i];
        cur_first = first_angle_r[i];
      end
    end

    diff = {item.angle[15], item.angle} - {cur_prev[15], cur_prev};
    if (diff < -17'sd4096) begin
      delta = {diff[16], diff} + 18'(ENC_WRAP);
    end else if (diff > 17'(HALF_TURN)) begin
      delta = {diff[16], diff} - 18'(ENC_WRAP);
    end else begin
      delta = {diff[16], diff};
    end

    sum = {{2{cur_total[31]}}, cur_total} + {{16{delta[17]}}, delta};
    if (sum > 34'sd2147483647) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum < -34'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[31:0];
    end

    new_total = cur_seen ? sat : '0;
    new_start = cur_seen ? cur_first : item.angle;

    result_nxt.slot        = item.slot;
    result_nxt.angle       = item.angle;
    result_nxt.speed       = item.speed;
    result_nxt.torque      = item.torque;
    result_nxt.temperature = item.temperature;
    result_nxt.total_angle = new_total;
    result_nxt.start_angle = new_start;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= result_nxt;
      for (int i = 0; i < USED_SLOTS; i++) begin
        if (sel[i]) begin
          prev_angle_r[i] <= item.angle;
          total_r[i]      <= new_total;
          first_angle_r[i] <= new_start;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seen_r      <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        seen_r      <= seen_r | sel;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.motor_slot  = out_r.slot;
  assign out_ch.angle       = out_r.angle;
  assign out_ch.speed       = out_r.speed;
  assign out_ch.torque      = out_r.torque;
  assign out_ch.temperature = out_r.temperature;
  assign out_ch.total_angle = out_r.total_angle;
  assign out_ch.start_angle = out_r.start_angle;

endmodule

>>> src/motor_feedback_multiturn_tracker.sv
// Multi-turn feedback tracker for bus-attached motors, top level.
// Accepts one frame per cycle while the queue is not full. A frame whose
// identifier matches a motor slot (base_id plus the slot's 4-bit id, lowest
// slot first, within base_id to base_id+10) yields one result; other frames
// yield none. The front end classifies frames and feeds a two-entry queue;
// the back end updates the slot's multi-turn total (compare, add, saturate)
// and holds the result in an output register, so throughput is one frame
// per cycle while out ready stays high. Configuration writes are always
// taken (cfg ready is tied high) and must happen only while idle.
module motor_feedback_multiturn_tracker import mft_pkg::*; #(
  parameter int MOTOR_SLOTS = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  mft_cfg_if.sink  cfg_ch,
  mft_in_if.sink   in_ch,
  mft_out_if.source out_ch
);

  localparam int USED_SLOTS = (MOTOR_SLOTS < MAX_IDS) ? MOTOR_SLOTS : MAX_IDS;

  logic          push;
  item_t         push_item;
  logic          pop;
  queue_status_t q_status;

  mft_front #(
    .USED_SLOTS (USED_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .in_ch     (in_ch),
    .q_full    (q_status.full),
    .push      (push),
    .push_item (push_item)
  );

  mft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .status    (q_status)
  );

  mft_back #(
    .USED_SLOTS (USED_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

>>> bench/tb_motor_feedback_multiturn_tracker.sv
// Testbench for the motor feedback multi-turn tracker.
`timescale 1ns / 100ps

module tb_motor_feedback_multiturn_tracker;
  import mft_pkg::*;

  localparam int SLOTS         = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam longint TOTAL_MAX = 64'sd2147483647;
  localparam longint TOTAL_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [ID_W-1:0]      fid;
    logic [PAYLOAD_W-1:0] payload;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n;

  mft_cfg_if cfg_ch();
  mft_in_if  in_ch();
  mft_out_if out_ch();

  motor_feedback_multiturn_tracker #(.MOTOR_SLOTS(SLOTS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_t  frames_to_send[$];
  result_t expected_feedback[$];
  frame_t  next_frame;
  result_t head_result;
  logic    frame_taken;
  int      in_idle_pct;
  int      out_stall_pct;
  int      quiet_cycles;
  int      errors;

  // tracker state as the block should hold it
  logic [ID_W-1:0]       trk_base;
  logic [COUNT_W-1:0]    trk_count;
  logic [CFG_DATA_W-1:0] trk_ids;
  logic signed [15:0]    trk_prev[SLOTS];
  logic                  trk_seen[SLOTS];
  logic signed [31:0]    trk_total[SLOTS];
  logic signed [15:0]    trk_start[SLOTS];

  // stimulus-side view of the current setting
  logic [ID_W-1:0]       cur_base;
  logic [COUNT_W-1:0]    cur_count;
  logic [CFG_DATA_W-1:0] cur_ids;
  logic [15:0]           last_sent[16];

  function automatic void track_frame(logic [ID_W-1:0] fid, logic [PAYLOAD_W-1:0] pl);
    int      live;
    int      hit;
    int      ang;
    int      last;
    int      d;
    longint  acc;
    result_t r;
    hit = -1;
    if (int'(fid) < int'(trk_base) || int'(fid) > int'(trk_base) + WINDOW_SPAN ||
        trk_count == 0)
      return;
    live = int'(trk_count);
    if (live > SLOTS) live = SLOTS;
    if (live > MAX_IDS) live = MAX_IDS;
    for (int i = 0; i < live; i++) begin
      if (hit < 0 && int'(trk_base) + int'(trk_ids[4*i +: 4]) == int'(fid)) hit = i;
    end
    if (hit < 0) return;
    ang = int'($signed(pl[63:48]));
    acc = longint'(trk_total[hit]);
    if (trk_seen[hit]) begin
      last = int'(trk_prev[hit]);
      d = ang - last;
      if (d < -HALF_TURN) acc = acc + (ENC_WRAP - last + ang);
      else if (d > HALF_TURN) acc = acc - (ENC_WRAP - ang + last);
      else acc = acc + d;
      if (acc > TOTAL_MAX) acc = TOTAL_MAX;
      if (acc < TOTAL_MIN) acc = TOTAL_MIN;
    end else begin
      trk_start[hit] = pl[63:48];
    end
    trk_total[hit] = acc[31:0];
    trk_prev[hit]  = pl[63:48];
    trk_seen[hit]  = 1'b1;
    r.slot        = hit[SLOT_W-1:0];
    r.angle       = pl[63:48];
    r.speed       = pl[47:32];
    r.torque      = pl[31:16];
    r.temperature = pl[15:8];
    r.total_angle = trk_total[hit];
    r.start_angle = trk_start[hit];
    expected_feedback.push_back(r);
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_taken <= 1'b0;
    end else begin
      frame_taken <= in_ch.valid && in_ch.ready;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          CFG_BASE_ID:     trk_base = cfg_ch.data[ID_W-1:0];
          CFG_MOTOR_COUNT: trk_count = cfg_ch.data[COUNT_W-1:0];
          CFG_SLOT_IDS:    trk_ids = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_feedback.size() == 0) begin
          $display("%0t: unexpected result for slot %0d, angle %0d", $time,
                   out_ch.motor_slot, out_ch.angle);
          errors++;
        end else begin
          head_result = expected_feedback.pop_front();
          compare_field("motor_slot", head_result.slot, out_ch.motor_slot);
          compare_field("angle", $signed(head_result.angle), $signed(out_ch.angle));
          compare_field("speed", $signed(head_result.speed), $signed(out_ch.speed));
          compare_field("torque", $signed(head_result.torque), $signed(out_ch.torque));
          compare_field("temperature", head_result.temperature, out_ch.temperature);
          compare_field("total_angle", $signed(head_result.total_angle),
                        $signed(out_ch.total_angle));
          compare_field("start_angle", $signed(head_result.start_angle),
                        $signed(out_ch.start_angle));
        end
      end
      if (in_ch.valid && in_ch.ready) track_frame(in_ch.frame_id, in_ch.payload);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || frame_taken) begin
      if (frames_to_send.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        next_frame = frames_to_send.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.frame_id <= next_frame.fid;
        in_ch.payload  <= next_frame.payload;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  task automatic send_frame(logic [ID_W-1:0] fid, logic [15:0] ang, logic [15:0] spd,
                            logic [15:0] trq, logic [7:0] tmp);
    frame_t f;
    f.fid     = fid;
    f.payload = {ang, spd, trq, tmp, 8'($urandom)};
    frames_to_send.push_back(f);
    while (frames_to_send.size() > 8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [ID_W-1:0] base, logic [COUNT_W-1:0] count,
                               logic [CFG_DATA_W-1:0] ids);
    write_reg(CFG_BASE_ID, CFG_DATA_W'(base));
    write_reg(CFG_MOTOR_COUNT, CFG_DATA_W'(count));
    write_reg(CFG_SLOT_IDS, ids);
    cur_base  = base;
    cur_count = count;
    cur_ids   = ids;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (frames_to_send.size() != 0 || in_ch.valid || expected_feedback.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle(logic [15:0] prev);
    int step;
    logic [15:0] a;
    case ($urandom_range(0, 7))
      0: begin
        step = HALF_TURN + $urandom_range(0, 1);
        a = $urandom_range(0, 1) ? 16'(int'($signed(prev)) + step)
                                 : 16'(int'($signed(prev)) - step);
      end
      1: a = 16'(int'($signed(prev)) + int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN);
      2, 3: a = 16'($urandom_range(0, ENC_WRAP));
      4: a = 16'($urandom);
      5: a = 16'hFFFF;
      6: a = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: a = prev;
    endcase
    return a;
  endfunction

  task automatic run_random(int n_aimed);
    int live;
    int aimed;
    int tries;
    int pick;
    int s;
    int off;
    logic [ID_W-1:0] fid;
    logic [15:0] ang;
    live = (cur_count > MAX_IDS) ? MAX_IDS : int'(cur_count);
    aimed = 0;
    tries = 0;
    while (aimed < n_aimed && tries < 3 * n_aimed) begin
      tries++;
      pick = $urandom_range(0, 99);
      if (pick < 75 && live > 0) begin
        s = $urandom_range(0, live - 1);
        off = int'(cur_ids[4*s +: 4]);
        if (off <= WINDOW_SPAN && int'(cur_base) + off < (1 << ID_W)) aimed++;
      end else if (pick < 90) begin
        off = $urandom_range(0, WINDOW_SPAN);
      end else begin
        off = -1;
      end
      if (off < 0) begin
        fid = ID_W'($urandom);
        ang = 16'($urandom);
      end else begin
        fid = ID_W'(int'(cur_base) + off);
        ang = pick_angle(last_sent[off]);
        last_sent[off] = ang;
      end
      send_frame(fid, ang, 16'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [ID_W-1:0] b;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.frame_id = '0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_BASE_ID;
    cfg_ch.data = '0;
    quiet_cycles = 0;
    errors = 0;
    trk_base  = BASE_ID_RST;
    trk_count = MOTOR_COUNT_RST;
    trk_ids   = SLOT_IDS_RST;
    cur_base  = BASE_ID_RST;
    cur_count = MOTOR_COUNT_RST;
    cur_ids   = SLOT_IDS_RST;
    for (int i = 0; i < SLOTS; i++) begin
      trk_prev[i]  = '0;
      trk_seen[i]  = 1'b0;
      trk_total[i] = '0;
      trk_start[i] = '0;
    end
    for (int i = 0; i < 16; i++) last_sent[i] = '0;
    in_idle_pct = 18;
    out_stall_pct = 76;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    b = BASE_ID_RST;
    send_frame(b - 11'd1, 16'h0100, 16'h0001, 16'h0002, 8'h03);
    send_frame(b + 11'd11, 16'h0100, 16'h0001, 16'h0002, 8'h03);
    send_frame(b, 16'h0100, 16'h0001, 16'h0002, 8'h03);
    send_frame('0, 16'h0100, 16'h0001, 16'h0002, 8'h03);
    send_frame('1, 16'h0100, 16'h0001, 16'h0002, 8'h03);
    send_frame(b + 11'd1, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF);
    send_frame(b + 11'd1, 16'd4095, 16'h8000, 16'h7FFF, 8'h00);
    send_frame(b + 11'd1, 16'd8192, 16'h1234, 16'hEDCB, 8'h5A);
    send_frame(b + 11'd1, 16'd4096, 16'h0000, 16'hFFFF, 8'hA5);
    send_frame(b + 11'd1, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h80);
    send_frame(b + 11'd2, 16'h8000, 16'h0001, 16'h0001, 8'h01);
    send_frame(b + 11'd2, 16'h7FFF, 16'h0001, 16'h0001, 8'h01);
    send_frame(b + 11'd2, 16'h8000, 16'h0001, 16'h0001, 8'h01);
    send_frame(b + 11'd3, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_frame(b + 11'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_frame(b + 11'd4, 16'd0, 16'h0010, 16'h0020, 8'h30);
    send_frame(b + 11'd4, 16'd8191, 16'h0010, 16'h0020, 8'h30);
    send_frame(b + 11'd4, 16'd0, 16'h0010, 16'h0020, 8'h30);
    send_frame(b + 11'd5, 16'h0100, 16'h0001, 16'h0002, 8'h03);
    send_frame(b + 11'd8, 16'h0100, 16'h0001, 16'h0002, 8'h03);
    send_frame(b + 11'd10, 16'h0100, 16'h0001, 16'h0002, 8'h03);
    settle();

    apply_setting(11'd0, 3'd4, 16'hA000);
    run_random(100);
    settle();
    apply_setting(11'd2047, 3'd1, 16'h0000);
    run_random(60);
    settle();

    in_idle_pct = 76;
    out_stall_pct = 18;
    apply_setting(11'd2040, 3'd7, 16'hFB75);
    run_random(80);
    settle();
    apply_setting(11'd1365, 3'd0, 16'hFFFF);
    run_random(15);
    settle();

    in_idle_pct = 0;
    out_stall_pct = 0;
    apply_setting(ID_W'($urandom_range(0, 2037)), 3'd3, 16'h0A55);
    run_random(100);
    settle();
    apply_setting(11'd512, 3'd4, 16'h4321);
    run_random(100);
    settle();

    if (expected_feedback.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, expected_feedback.size());
    if (errors == 0 && expected_feedback.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
src/mft_pkg.sv
src/mft_ifs.sv
src/mft_front.sv
src/mft_queue.sv
src/mft_back.sv
src/motor_feedback_multiturn_tracker.sv
bench/tb_motor_feedback_multiturn_tracker.sv
